// ===== rtl/accel_mean_step_counter_top_macros.svh =====
// Assertion helpers, clocked on clk and disabled during reset.
`ifndef ACCEL_MEAN_STEP_COUNTER_TOP_MACROS_SVH
`define ACCEL_MEAN_STEP_COUNTER_TOP_MACROS_SVH

// same-cycle implication
`define AMSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AMSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/amsc_pkg.sv =====
package amsc_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int DELTA_W        = SAMPLE_W + 1;
    localparam int MEAN_W         = 16;
    localparam int SQ_W           = 2 * MEAN_W;
    localparam int THR_W          = 16;
    localparam int DIST_W         = 8;
    localparam int CNT_W          = 32;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int WINDOW_LEN_DEF = 10;

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(384);
    localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(9);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_THRESHOLD    = 2'd0,
        CFG_DISTANCE_PER_STEP = 2'd1
    } amsc_cfg_idx_t;

    // one load strobe per pipeline stage; s1 is the input accept
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } amsc_load_t;

endpackage

// ===== rtl/amsc_if.sv =====
interface amsc_sample_if import amsc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

interface amsc_result_if import amsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] step_total;
    logic [CNT_W-1:0] distance_total;
    logic             step_seen;
    logic             above_threshold;

    modport source (output valid, output step_total, output distance_total,
                    output step_seen, output above_threshold, input ready);
    modport sink   (input valid, input step_total, input distance_total,
                    input step_seen, input above_threshold, output ready);
endinterface

// ===== rtl/accel_mean_step_counter_top.sv =====
// channel   | dir | words                                   | accept
// ----------+-----+-----------------------------------------+---------------------
// samples   | in  | sample_x/y/z, signed 16 bit each        | valid && ready
// results   | out | step_total, distance_total, step_seen,  | valid && ready
//           |     | above_threshold                         |
// cfg       | in  | cfg_index, cfg_data (write only)        | cfg_we
//
// One word per cycle sustained while results are taken; a result is valid
// once its word has moved from S1 through S7, and leaves when results.ready is high.
// The rate is set by the ring memory port: one read-first
// read/write per accept, and the running sums advance one word per cycle while S2 loads.
// Reset clears counters, sums and the per-slot valid bits; no clearing pass.
// Each stage stalls only when the one after it is full and not draining,
// so the block keeps taking samples while a result waits at the output,
// until all seven stages hold a word.
`include "accel_mean_step_counter_top_macros.svh"

module accel_mean_step_counter_top import amsc_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    amsc_sample_if.sink           samples,
    amsc_result_if.source         results
);

    localparam int STAGES = 7;

    // config registers
    logic [THR_W-1:0]  thr_reg;
    logic [DIST_W-1:0] dist_reg;

    // pipeline control
    logic [STAGES:1] v_reg, v_next;
    logic [STAGES:1] adv, free, load_vec;
    logic            accept;
    amsc_load_t      ld;

    // datapath between units
    logic signed [DELTA_W-1:0] delta_x, delta_y, delta_z;
    logic [MEAN_W-1:0]         mean_x, mean_y, mean_z;

    // --- configuration: out-of-range index is dropped ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            dist_reg <= DIST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_THRESHOLD:    thr_reg  <= cfg_data[THR_W-1:0];
                CFG_DISTANCE_PER_STEP: dist_reg <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // --- stage handshake: a stage moves when the next has room ---
    always_comb
    begin
        adv[STAGES]  = v_reg[STAGES] && results.ready;
        free[STAGES] = !v_reg[STAGES] || results.ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            adv[k]  = v_reg[k] && free[k+1];
            free[k] = !v_reg[k] || adv[k];
        end
        accept = samples.valid && free[1];
        load_vec[1] = accept;
        for (int k = 2; k <= STAGES; k++)
            load_vec[k] = adv[k-1];
        for (int k = 1; k <= STAGES; k++)
            v_next[k] = load_vec[k] || (v_reg[k] && !adv[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign ld = '{s1: load_vec[1], s2: load_vec[2], s3: load_vec[3], s4: load_vec[4],
                  s5: load_vec[5], s6: load_vec[6], s7: load_vec[7]};

    assign samples.ready = free[1];
    assign results.valid = v_reg[STAGES];

    // --- units ---
    // S1: ring memory, evicted sample and per-axis delta
    amsc_ring #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .sample_x (samples.sample_x),
        .sample_y (samples.sample_y),
        .sample_z (samples.sample_z),
        .delta_x  (delta_x),
        .delta_y  (delta_y),
        .delta_z  (delta_z)
    );

    // S2..S4: running sum, rounding, divide by window length
    amsc_mean #(.WINDOW_LEN (WINDOW_LEN)) u_mean_x (
        .clk (clk), .rst_n (rst_n), .ld (ld), .delta (delta_x), .mean_mag (mean_x)
    );
    amsc_mean #(.WINDOW_LEN (WINDOW_LEN)) u_mean_y (
        .clk (clk), .rst_n (rst_n), .ld (ld), .delta (delta_y), .mean_mag (mean_y)
    );
    amsc_mean #(.WINDOW_LEN (WINDOW_LEN)) u_mean_z (
        .clk (clk), .rst_n (rst_n), .ld (ld), .delta (delta_z), .mean_mag (mean_z)
    );

    // S5..S7: squares, threshold compare, step and distance counters
    amsc_detect u_detect (
        .clk             (clk),
        .rst_n           (rst_n),
        .ld              (ld),
        .mean_x          (mean_x),
        .mean_y          (mean_y),
        .mean_z          (mean_z),
        .threshold       (thr_reg),
        .distance_step   (dist_reg),
        .step_total      (results.step_total),
        .distance_total  (results.distance_total),
        .step_seen       (results.step_seen),
        .above_threshold (results.above_threshold)
    );

    // --- checks ---
    `AMSC_ASSERT_NOW(a_seen_above, results.valid, !results.step_seen || results.above_threshold, "step counted below threshold")
    `AMSC_ASSERT_NEXT(a_step_inc, ld.s7, results.step_total == $past(results.step_total) + 32'(results.step_seen), "step count off by more than the new step")
    `AMSC_ASSERT_NEXT(a_cnt_hold, !ld.s7, $stable(results.step_total) && $stable(results.distance_total), "counters moved without a new word")

endmodule

// ===== rtl/amsc_ring.sv =====
module amsc_ring import amsc_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  amsc_load_t                ld,
    input  logic signed [SAMPLE_W-1:0] sample_x,
    input  logic signed [SAMPLE_W-1:0] sample_y,
    input  logic signed [SAMPLE_W-1:0] sample_z,
    output logic signed [DELTA_W-1:0]  delta_x,
    output logic signed [DELTA_W-1:0]  delta_y,
    output logic signed [DELTA_W-1:0]  delta_z
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WORD_W = 3 * SAMPLE_W;

    logic [WORD_W-1:0]     mem [WINDOW_LEN];
    logic [SLOT_W-1:0]     slot_reg;
    logic [WINDOW_LEN-1:0] ok_reg;
    logic [WORD_W-1:0]     old_reg;
    logic                  old_ok_reg;
    logic signed [SAMPLE_W-1:0] new_x_reg, new_y_reg, new_z_reg;
    logic signed [SAMPLE_W-1:0] old_x, old_y, old_z;

    // read-first port: the evicted word comes out as the new one goes in
    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            old_reg          <= mem[slot_reg];
            mem[slot_reg]    <= {sample_x, sample_y, sample_z};
            old_ok_reg       <= ok_reg[slot_reg];
            new_x_reg        <= sample_x;
            new_y_reg        <= sample_y;
            new_z_reg        <= sample_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            ok_reg   <= '0;
        end
        else if (ld.s1)
        begin
            ok_reg[slot_reg] <= 1'b1;
            if (slot_reg == SLOT_W'(WINDOW_LEN - 1))
                slot_reg <= '0;
            else
                slot_reg <= slot_reg + SLOT_W'(1);
        end
    end

    // never-written slots read as zero
    assign old_x = old_ok_reg ? old_reg[3*SAMPLE_W-1:2*SAMPLE_W] : '0;
    assign old_y = old_ok_reg ? old_reg[2*SAMPLE_W-1:SAMPLE_W]   : '0;
    assign old_z = old_ok_reg ? old_reg[SAMPLE_W-1:0]            : '0;

    assign delta_x = DELTA_W'(new_x_reg) - DELTA_W'(old_x);
    assign delta_y = DELTA_W'(new_y_reg) - DELTA_W'(old_y);
    assign delta_z = DELTA_W'(new_z_reg) - DELTA_W'(old_z);

endmodule

// ===== rtl/amsc_mean.sv =====
module amsc_mean import amsc_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  amsc_load_t                ld,
    input  logic signed [DELTA_W-1:0] delta,
    output logic [MEAN_W-1:0]         mean_mag
);

    localparam int CLOG  = $clog2(WINDOW_LEN);
    localparam int A_W   = SAMPLE_W + CLOG;
    localparam int SUM_W = A_W + 1;
    localparam int T_W   = SUM_W + 1;
    localparam int K     = A_W + CLOG;
    localparam int M_W   = A_W + 2;
    localparam int P_W   = A_W + M_W;

    // ceil(2^K / N): exact floor division for any dividend below 2^A_W
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam logic signed [T_W-1:0] HALF_LO = T_W'(WINDOW_LEN / 2);
    localparam logic signed [T_W-1:0] HALF_HI = T_W'((WINDOW_LEN + 1) / 2);

    logic signed [SUM_W-1:0] sum_reg;
    logic [A_W-1:0]          abs_reg;
    logic [MEAN_W-1:0]       q_reg;
    logic signed [T_W-1:0]   s_ext, t, t_abs;
    logic [P_W-1:0]          prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (ld.s2)
            sum_reg <= sum_reg + SUM_W'(delta);
    end

    // (2s+N)/2 truncated toward zero; odd N rounds differently below zero
    always_comb
    begin
        s_ext = T_W'(sum_reg);
        if (s_ext >= -HALF_LO)
            t = s_ext + HALF_LO;
        else
            t = s_ext + HALF_HI;
        t_abs = t[T_W-1] ? -t : t;
    end

    assign prod = P_W'(abs_reg) * P_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (ld.s3)
            abs_reg <= A_W'(t_abs);
        if (ld.s4)
            q_reg <= prod[K +: MEAN_W];
    end

    assign mean_mag = q_reg;

endmodule

// ===== rtl/amsc_detect.sv =====
module amsc_detect import amsc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  amsc_load_t        ld,
    input  logic [MEAN_W-1:0] mean_x,
    input  logic [MEAN_W-1:0] mean_y,
    input  logic [MEAN_W-1:0] mean_z,
    input  logic [THR_W-1:0]  threshold,
    input  logic [DIST_W-1:0] distance_step,
    output logic [CNT_W-1:0]  step_total,
    output logic [CNT_W-1:0]  distance_total,
    output logic              step_seen,
    output logic              above_threshold
);

    localparam int MAG_W    = SQ_W + 2;
    localparam int THR_SQ_W = 2 * THR_W;

    logic [SQ_W-1:0]     sq_x_reg, sq_y_reg, sq_z_reg;
    logic [THR_SQ_W-1:0] thr_sq_reg;
    logic [MAG_W-1:0]    mag_sq;
    logic                above_reg;
    logic                stepping_reg;
    logic [CNT_W-1:0]    step_cnt_reg, dist_cnt_reg;
    logic                seen_reg, above_out_reg;

    always_ff @(posedge clk)
    begin
        if (ld.s5)
        begin
            sq_x_reg   <= SQ_W'(mean_x) * SQ_W'(mean_x);
            sq_y_reg   <= SQ_W'(mean_y) * SQ_W'(mean_y);
            sq_z_reg   <= SQ_W'(mean_z) * SQ_W'(mean_z);
            thr_sq_reg <= THR_SQ_W'(threshold) * THR_SQ_W'(threshold);
        end
        if (ld.s6)
            above_reg <= (mag_sq >= MAG_W'(thr_sq_reg));
    end

    assign mag_sq = MAG_W'(sq_x_reg) + MAG_W'(sq_y_reg) + MAG_W'(sq_z_reg);

    // rising crossing counts one step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stepping_reg  <= 1'b0;
            step_cnt_reg  <= '0;
            dist_cnt_reg  <= '0;
            seen_reg      <= 1'b0;
            above_out_reg <= 1'b0;
        end
        else if (ld.s7)
        begin
            above_out_reg <= above_reg;
            seen_reg      <= above_reg && !stepping_reg;
            stepping_reg  <= above_reg;
            if (above_reg && !stepping_reg)
            begin
                step_cnt_reg <= step_cnt_reg + CNT_W'(1);
                dist_cnt_reg <= dist_cnt_reg + CNT_W'(distance_step);
            end
        end
    end

    assign step_total      = step_cnt_reg;
    assign distance_total  = dist_cnt_reg;
    assign step_seen       = seen_reg;
    assign above_threshold = above_out_reg;

endmodule

// ===== tb/sv/accel_mean_step_counter_top_tb.sv =====
`timescale 1ns / 1ps

module accel_mean_step_counter_top_tb import amsc_pkg::*; ();

    localparam int          WIN         = WINDOW_LEN_DEF;
    // sample to result, in cycles
    localparam int          LATENCY     = 7;
    // generous cap, well above the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 600000;

    // unused register slots; writes there must not disturb anything
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // one expected result word
    typedef struct {
        logic [CNT_W-1:0] step_total;
        logic [CNT_W-1:0] distance_total;
        logic             step_seen;
        logic             above_threshold;
    } totals_t;

    // ------------------------------------------------------------------
    // Pedometer scoreboard: own copy of the rings, running sums, step
    // state and registers; one expected word queued per accepted sample.
    // ------------------------------------------------------------------
    class pedometer_scoreboard;
        logic signed [SAMPLE_W-1:0] ring_x [WIN];
        logic signed [SAMPLE_W-1:0] ring_y [WIN];
        logic signed [SAMPLE_W-1:0] ring_z [WIN];
        int unsigned                slot;
        int                         sum_x, sum_y, sum_z;
        bit                         stepping;
        logic [CNT_W-1:0]           step_count;
        logic [CNT_W-1:0]           distance_count;
        logic [THR_W-1:0]           threshold;
        logic [DIST_W-1:0]          stride;
        totals_t                    expected_totals[$];
        int unsigned                errors;
        int unsigned                words_checked;
        int unsigned                steps_flagged;
        int unsigned                above_words;

        function new();
            for (int i = 0; i < WIN; i++)
            begin
                ring_x[i] = '0;
                ring_y[i] = '0;
                ring_z[i] = '0;
            end
            slot           = 0;
            sum_x          = 0;
            sum_y          = 0;
            sum_z          = 0;
            stepping       = 1'b0;
            step_count     = '0;
            distance_count = '0;
            threshold      = THR_RESET;
            stride         = DIST_RESET;
            errors         = 0;
            words_checked  = 0;
            steps_flagged  = 0;
            above_words    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STEP_THRESHOLD:    threshold = data[THR_W-1:0];
                CFG_DISTANCE_PER_STEP: stride    = data[DIST_W-1:0];
                default: ;
            endcase
        endfunction

        // (2*sum + N)/2/N, both divisions truncating toward zero
        function int axis_mean(int sum);
            int half;
            half = (2 * sum + WIN) / 2;
            return half / WIN;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] nx,
                                  logic signed [SAMPLE_W-1:0] ny,
                                  logic signed [SAMPLE_W-1:0] nz);
            longint  mx, my, mz, mag_sq, thr_sq;
            bit      above;
            totals_t t;
            sum_x += int'(nx) - int'(ring_x[slot]);
            sum_y += int'(ny) - int'(ring_y[slot]);
            sum_z += int'(nz) - int'(ring_z[slot]);
            ring_x[slot] = nx;
            ring_y[slot] = ny;
            ring_z[slot] = nz;
            slot = (slot + 1 >= WIN) ? 0 : slot + 1;

            mx     = axis_mean(sum_x);
            my     = axis_mean(sum_y);
            mz     = axis_mean(sum_z);
            mag_sq = mx * mx + my * my + mz * mz;
            thr_sq = longint'(threshold) * longint'(threshold);
            above  = (mag_sq >= thr_sq);

            t.step_seen = 1'b0;
            if (above)
            begin
                if (!stepping)
                begin
                    stepping       = 1'b1;
                    step_count     = step_count + 1;
                    distance_count = distance_count + {{(CNT_W-DIST_W){1'b0}}, stride};
                    t.step_seen    = 1'b1;
                end
            end
            else
                stepping = 1'b0;

            t.step_total      = step_count;
            t.distance_total  = distance_count;
            t.above_threshold = above;
            expected_totals.push_back(t);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [CNT_W-1:0] step_total, logic [CNT_W-1:0] distance_total,
                          logic step_seen, logic above_threshold);
            totals_t t;
            if (expected_totals.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            t = expected_totals.pop_front();
            words_checked++;
            if (t.step_seen)
                steps_flagged++;
            if (t.above_threshold)
                above_words++;
            if (step_total !== t.step_total)
                report($sformatf("word %0d step_total %0d, expected %0d",
                                 words_checked, step_total, t.step_total));
            if (distance_total !== t.distance_total)
                report($sformatf("word %0d distance_total %0d, expected %0d",
                                 words_checked, distance_total, t.distance_total));
            if (step_seen !== t.step_seen)
                report($sformatf("word %0d step_seen %b, expected %b",
                                 words_checked, step_seen, t.step_seen));
            if (above_threshold !== t.above_threshold)
                report($sformatf("word %0d above_threshold %b, expected %b",
                                 words_checked, above_threshold, t.above_threshold));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    amsc_sample_if samples_if ();
    amsc_result_if results_if ();

    pedometer_scoreboard sb;
    bit                  idle_on;      // random gaps/stalls enabled
    int unsigned         cycle_count;

    accel_mean_step_counter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .results   (results_if)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready drops for random bursts while idling is on; it
    // changes only at the falling edge.
    // ------------------------------------------------------------------
    initial
    begin
        results_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                results_if.ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            results_if.ready = 1'b1;
        end
    end

    // every accepted result word goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1)
            sb.check_result(results_if.step_total, results_if.distance_total,
                            results_if.step_seen, results_if.above_threshold);
    end

    // ------------------------------------------------------------------
    // Drivers. All called and returning at a falling edge.
    // ------------------------------------------------------------------

    // Present one sample word, hold it until taken, note it on acceptance.
    // valid stays high on return so back-to-back words need no toggle.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                               input logic signed [SAMPLE_W-1:0] y,
                               input logic signed [SAMPLE_W-1:0] z);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            samples_if.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        samples_if.valid    = 1'b1;
        samples_if.sample_x = x;
        samples_if.sample_y = y;
        samples_if.sample_z = z;
        do
            @(posedge clk);
        while (samples_if.ready !== 1'b1);
        sb.note_sample(x, y, z);
        @(negedge clk);
    endtask

    // Sender holds off until every expected word is back, then lets the
    // pipeline settle; registers are only touched after this.
    task automatic wait_drained();
        samples_if.valid = 1'b0;
        while (sb.expected_totals.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] clamp16(int v);
        if (v > 32767)
            return SAMPLE_MAX;
        if (v < -32768)
            return SAMPLE_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Walking pattern: bursts above the threshold on one axis, then quiet
    // bursts well under it, so the windowed mean crosses up and down.
    // Bursts of 3..16 words; short ones may never lift the mean (broken
    // strides). About one word in ten is full-range noise.
    task automatic run_walk(input int unsigned count, input logic [THR_W-1:0] thr);
        int unsigned done;
        int unsigned burst;
        int          t;
        int          amp;
        int          noise;
        int          axis;
        int          v [3];
        bit          high;
        t     = thr;
        noise = t / 4;
        done  = 0;
        high  = $urandom_range(0, 1);
        while (done < count)
        begin
            burst = $urandom_range(3, 16);
            axis  = $urandom_range(0, 2);
            amp   = t + int'($urandom_range(0, t)) + 1;
            if ($urandom_range(0, 1))
                amp = -amp;
            for (int k = 0; k < burst && done < count; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_sample(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()),
                                SAMPLE_W'($urandom()));
                else
                begin
                    for (int a = 0; a < 3; a++)
                        v[a] = jitter(noise);
                    if (high)
                        v[axis] = amp + jitter(noise);
                    send_sample(clamp16(v[0]), clamp16(v[1]), clamp16(v[2]));
                end
                done++;
            end
            high = !high;
        end
    endtask

    // one random phase: settle, rewrite every register, stream samples
    task automatic run_phase(input logic [THR_W-1:0] thr, input logic [CFG_DATA_W-1:0] dist_word,
                             input int unsigned count, input bit idle);
        wait_drained();
        // stray write to an unused index first; must be ignored
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom()));
        write_reg(CFG_STEP_THRESHOLD, thr);
        write_reg(CFG_DISTANCE_PER_STEP, dist_word);
        idle_on = idle;
        run_walk(count, thr);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_STEP_THRESHOLD;
        cfg_data            = '0;
        samples_if.valid    = 1'b0;
        samples_if.sample_x = '0;
        samples_if.sample_y = '0;
        samples_if.sample_z = '0;
        idle_on             = 1'b1;
        sb                  = new();

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed, reset register values. The first words see a ring
        // that is mostly still zero from reset (partial window).
        send_sample('0, '0, '0);
        repeat (8) send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);   // rising crossing
        repeat (8) send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);   // through zero, negative sums
        send_sample(SAMPLE_MAX, SAMPLE_MIN, -16'sd1);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, 16'sd1);
        send_sample(-16'sd1, 16'sd1, SAMPLE_MIN);
        send_sample(16'sd383, -16'sd384, 16'sd384);                   // near the default threshold
        repeat (4) send_sample('0, '0, '0);                           // zeros, mean stays above

        // register extremes; distance written wider than 8 bits keeps low byte
        run_phase(16'd0,     16'hFFFF, 100, 1'b1);   // always above: stepping held, no new step
        run_phase(16'hFFFF,  16'h0000, 100, 1'b1);   // never reachable
        for (int p = 0; p < 4; p++)
            run_phase(THR_W'($urandom_range(64, 4000)), CFG_DATA_W'($urandom()), 300, p != 1);
        run_phase(THR_W'($urandom()), CFG_DATA_W'($urandom()), 150, 1'b1);
        // last stretch runs flat out on both sides
        run_phase(THR_RESET, 16'hA500 | CFG_DATA_W'(DIST_RESET), 200, 1'b0);

        wait_drained();

        if (sb.expected_totals.size() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.expected_totals.size()));

        $display("Checked %0d result words over 9 register settings; %0d steps flagged,",
                 sb.words_checked, sb.steps_flagged);
        $display("%0d words at or above threshold, final totals %0d steps / %0d distance",
                 sb.above_words, sb.step_count, sb.distance_count);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
